>>> design/wbim_pkg.sv
// Shared types, constants and arithmetic helpers for the wind-bent instance matrix block.
package wbim_pkg;

  localparam logic [29:0] TURN_K      = 30'd683565276;  // 2^32 / (2*pi)
  localparam logic [29:0] CORDIC_GAIN = 30'd652032874;
  localparam logic [17:0] MUL_3P7     = 18'd242483;
  localparam logic [17:0] MUL_2P3     = 18'd150733;
  localparam int          BEND_MAX    = 7143;           // 0.436 rad in Q2.14
  localparam int          ONE_Q14     = 16384;

  localparam int CORDIC_ITERS  = 16;
  localparam int CORDIC_STAGES = CORDIC_ITERS / 2;

  // stage positions along the main pipeline
  localparam int STG_YAW   = 18;  // yaw read by the tilt stage
  localparam int STG_SCALE = 32;  // width and height read by the scale stage
  localparam int LAT       = 34;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIR_X      = 3'd0,
    REG_DIR_Z      = 3'd1,
    REG_SPEED      = 3'd2,
    REG_STRENGTH   = 3'd3,
    REG_TURBULENCE = 3'd4,
    REG_FRAME_TIME = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [15:0] yaw;
    logic        [15:0] width;
    logic        [15:0] height;
  } side_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [31:0] z;
  } cvec_t;

  function automatic logic signed [31:0] atan_turn(logic [3:0] i);
    logic signed [31:0] a;
    case (i)
      4'd0:    a = 32'sd536870912;
      4'd1:    a = 32'sd316933406;
      4'd2:    a = 32'sd167458907;
      4'd3:    a = 32'sd85004756;
      4'd4:    a = 32'sd42667331;
      4'd5:    a = 32'sd21354465;
      4'd6:    a = 32'sd10679838;
      4'd7:    a = 32'sd5340245;
      4'd8:    a = 32'sd2670163;
      4'd9:    a = 32'sd1335087;
      4'd10:   a = 32'sd667544;
      4'd11:   a = 32'sd333772;
      4'd12:   a = 32'sd166886;
      4'd13:   a = 32'sd83443;
      4'd14:   a = 32'sd41721;
      4'd15:   a = 32'sd20861;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

  function automatic cvec_t cordic_iter(cvec_t v, logic [3:0] i);
    cvec_t r;
    if (v.z >= 0) begin
      r.x = v.x - (v.y >>> i);
      r.y = v.y + (v.x >>> i);
      r.z = v.z - atan_turn(i);
    end else begin
      r.x = v.x + (v.y >>> i);
      r.y = v.y - (v.x >>> i);
      r.z = v.z + atan_turn(i);
    end
    return r;
  endfunction

  // round a Q2.30 value to Q2.14 and saturate at +-1.0
  function automatic logic signed [15:0] sat_q14(logic signed [33:0] v);
    logic signed [33:0] r;
    logic signed [15:0] o;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'(ONE_Q14))       o = 16'(ONE_Q14);
    else if (r < -34'(ONE_Q14)) o = -16'(ONE_Q14);
    else                        o = 16'(r);
    return o;
  endfunction

endpackage

>>> design/wbim_if.sv
// Valid/ready channel interfaces for blade instances and instance matrices.
interface wbim_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        [15:0] blade_yaw;
  logic        [15:0] width_scale;
  logic        [15:0] height_scale;
  logic signed [31:0] sway_phase;

  modport source (output valid, pos_x, pos_y, pos_z, blade_yaw, width_scale,
                  height_scale, sway_phase, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, blade_yaw, width_scale,
                  height_scale, sway_phase, output ready);
endinterface

interface wbim_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m02;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] m12;
  logic signed [31:0] m20;
  logic signed [31:0] m21;
  logic signed [31:0] m22;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  trans_x, trans_y, trans_z, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  trans_x, trans_y, trans_z, output ready);
endinterface

>>> design/wbim_phase.sv
// Six-stage wind phase unit: phase from time and speed, both sine angles in turns.
module wbim_phase import wbim_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic        [29:0] frame_time,
  input  logic        [15:0] phase_rate,
  input  logic signed [31:0] sway,
  output logic        [31:0] ang1,
  output logic        [31:0] ang2
);

  logic        [45:0] p0;
  logic signed [31:0] sway1, sway2;
  logic signed [39:0] ph;
  logic        [23:0] ph_lo;
  logic signed [15:0] ph_hi;
  logic signed [23:0] hi24;
  logic        [53:0] a1;
  logic        [23:0] a2;
  logic        [41:0] b1;
  logic signed [33:0] b2;
  logic signed [49:0] b3;
  logic        [47:0] sum48;
  logic        [31:0] ang1_4, ang1_5;
  logic        [63:0] u;
  logic        [61:0] c1;
  logic        [31:0] c2;
  logic        [63:0] sum64;

  assign ph_lo = ph[23:0];
  assign ph_hi = $signed(ph[39:24]);
  assign hi24  = 24'(ph_hi);
  assign sum48 = a1[47:0] + {a2, 24'b0} + 48'h8000;
  assign sum64 = 64'(c1) + {c2, 32'b0} + 64'h8000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      p0     <= 46'(frame_time) * 46'(phase_rate);
      sway1  <= sway;
      ph     <= $signed({2'b00, p0[45:8]}) + 40'(sway1);
      sway2  <= sway1;
      // split the phase so every product stays narrow; only low bits survive
      a1     <= 54'(ph_lo) * 54'(TURN_K);
      a2     <= hi24 * TURN_K[23:0];
      b1     <= 42'(ph_lo) * 42'(MUL_3P7);
      b2     <= 34'(ph_hi) * 34'($signed({1'b0, MUL_3P7}));
      b3     <= 50'(sway2) * 50'($signed({1'b0, MUL_2P3}));
      ang1_4 <= sum48[47:16];
      u      <= 64'(b1) + {{6{b2[33]}}, b2, 24'b0} + 64'(b3);
      ang1_5 <= ang1_4;
      c1     <= 62'(u[31:0]) * 62'(TURN_K);
      c2     <= u[63:32] * 32'(TURN_K);
      ang1   <= ang1_5;
      ang2   <= sum64[63:32];
    end
  end

endmodule

>>> design/wbim_cordic.sv
// Pipelined sine/cosine: quadrant fold, two CORDIC rotations per stage, round.
module wbim_cordic import wbim_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic        [31:0] ang,
  output logic signed [15:0] sn,
  output logic signed [15:0] cs
);

  cvec_t              v_q    [CORDIC_STAGES+1];
  logic               flip_q [CORDIC_STAGES+1];
  logic signed [32:0] z_w;
  logic signed [32:0] z_f;
  logic               flip_f;
  logic signed [15:0] xs, ys;

  // fold into +-1/4 turn by a half turn
  always_comb begin
    z_w    = 33'($signed(ang));
    z_f    = z_w;
    flip_f = 1'b0;
    if (z_w > 33'sd1073741824) begin
      z_f    = z_w - 33'sd2147483648;
      flip_f = 1'b1;
    end else if (z_w < -33'sd1073741824) begin
      z_f    = z_w + 33'sd2147483648;
      flip_f = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_q[0].x  <= 34'($signed({1'b0, CORDIC_GAIN}));
      v_q[0].y  <= '0;
      v_q[0].z  <= 32'(z_f);
      flip_q[0] <= flip_f;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        v_q[g+1]    <= cordic_iter(cordic_iter(v_q[g], 4'(2*g)), 4'(2*g+1));
        flip_q[g+1] <= flip_q[g];
      end
    end
  end

  assign xs = sat_q14(v_q[CORDIC_STAGES].x);
  assign ys = sat_q14(v_q[CORDIC_STAGES].y);

  always_ff @(posedge clk) begin
    if (en) begin
      cs <= flip_q[CORDIC_STAGES] ? -xs : xs;
      sn <= flip_q[CORDIC_STAGES] ? -ys : ys;
    end
  end

endmodule

>>> design/wbim_bend.sv
// Four-stage bend unit: weighted sines, clamp, split into tilt angles, yaw angle.
module wbim_bend import wbim_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] s1,
  input  logic signed [15:0] s2,
  input  logic        [14:0] strength,
  input  logic        [14:0] turbulence,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_z,
  input  logic        [15:0] yaw,
  output logic        [31:0] tilt_x_ang,
  output logic        [31:0] tilt_z_ang,
  output logic        [31:0] yaw_ang
);

  logic signed [31:0] p1, p2;
  logic signed [32:0] bsum;
  logic signed [32:0] bq;
  logic signed [13:0] flex_c;
  logic signed [13:0] flex;
  logic signed [29:0] tx, tz;
  logic signed [60:0] px, pz;
  logic        [45:0] py;

  assign bsum = 33'(p1) + 33'(p2) + 33'sd8192;
  assign bq   = bsum >>> 14;

  always_comb begin
    if (bq > 33'(BEND_MAX))       flex_c = 14'(BEND_MAX);
    else if (bq < -33'(BEND_MAX)) flex_c = -14'(BEND_MAX);
    else                          flex_c = 14'(bq);
  end

  assign px = 61'(tx) * 61'($signed({1'b0, TURN_K})) + 61'sd134217728;
  assign pz = 61'(tz) * 61'($signed({1'b0, TURN_K})) + 61'sd134217728;
  assign py = 46'(yaw) * 46'(TURN_K) + 46'd4096;

  always_ff @(posedge clk) begin
    if (en) begin
      p1         <= 32'(s1) * 32'($signed({1'b0, strength}));
      p2         <= 32'(s2) * 32'($signed({1'b0, turbulence}));
      flex       <= flex_c;
      tx         <= -(30'(flex) * 30'(dir_z));
      tz         <= 30'(flex) * 30'(dir_x);
      tilt_x_ang <= px[59:28];
      tilt_z_ang <= pz[59:28];
      yaw_ang    <= py[44:13];
    end
  end

endmodule

>>> design/wbim_matrix.sv
// Four-stage matrix unit: Rz*Ry, then Rx, then column scaling to Q16.16.
module wbim_matrix import wbim_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] txs,
  input  logic signed [15:0] txc,
  input  logic signed [15:0] tzs,
  input  logic signed [15:0] tzc,
  input  logic signed [15:0] yws,
  input  logic signed [15:0] ywc,
  input  logic        [15:0] wid,
  input  logic        [15:0] hgt,
  output logic signed [31:0] m00,
  output logic signed [31:0] m01,
  output logic signed [31:0] m02,
  output logic signed [31:0] m10,
  output logic signed [31:0] m11,
  output logic signed [31:0] m12,
  output logic signed [31:0] m20,
  output logic signed [31:0] m21,
  output logic signed [31:0] m22
);

  function automatic logic signed [17:0] rnd14(logic signed [34:0] p);
    logic signed [34:0] r;
    r = (p + 35'sd8192) >>> 14;
    return 18'(r);
  endfunction

  function automatic logic signed [31:0] scl(logic signed [17:0] q, logic [15:0] s);
    logic signed [39:0] p;
    p = 40'(q) * 40'($signed({1'b0, s})) + 40'sd32;
    return p[37:6];
  endfunction

  logic signed [17:0] q00, q01, q02, b10, b11, b12, b20, b22, txc1, txs1;
  logic signed [17:0] q00b, q01b, q02b, q00c, q01c, q02c;
  logic signed [33:0] pa, pb, pc, pd, pe, pf, pg, ph, pi, pj;
  logic signed [17:0] q10, q11, q12, q20, q21, q22;

  always_ff @(posedge clk) begin
    if (en) begin
      q00  <= rnd14(35'(tzc) * 35'(ywc));
      q02  <= rnd14(35'(tzc) * 35'(yws));
      b10  <= rnd14(35'(tzs) * 35'(ywc));
      b12  <= rnd14(35'(tzs) * 35'(yws));
      q01  <= -18'(tzs);
      b11  <= 18'(tzc);
      b20  <= -18'(yws);
      b22  <= 18'(ywc);
      txc1 <= 18'(txc);
      txs1 <= 18'(txs);

      pa   <= 34'(txc1) * 34'(b10);
      pb   <= 34'(txs1) * 34'(b20);
      pc   <= 34'(txc1) * 34'(b11);
      pd   <= 34'(txc1) * 34'(b12);
      pe   <= 34'(txs1) * 34'(b22);
      pf   <= 34'(txs1) * 34'(b10);
      pg   <= 34'(txc1) * 34'(b20);
      ph   <= 34'(txs1) * 34'(b11);
      pi   <= 34'(txs1) * 34'(b12);
      pj   <= 34'(txc1) * 34'(b22);
      q00b <= q00;
      q01b <= q01;
      q02b <= q02;

      q10  <= rnd14(35'(pa) - 35'(pb));
      q11  <= rnd14(35'(pc));
      q12  <= rnd14(35'(pd) - 35'(pe));
      q20  <= rnd14(35'(pf) + 35'(pg));
      q21  <= rnd14(35'(ph));
      q22  <= rnd14(35'(pi) + 35'(pj));
      q00c <= q00b;
      q01c <= q01b;
      q02c <= q02b;

      m00  <= scl(q00c, wid);
      m01  <= scl(q10, wid);
      m02  <= scl(q20, wid);
      m10  <= scl(q01c, hgt);
      m11  <= scl(q11, hgt);
      m12  <= scl(q21, hgt);
      m20  <= scl(q02c, wid);
      m21  <= scl(q12, wid);
      m22  <= scl(q22, wid);
    end
  end

endmodule

>>> design/wind_bent_instance_matrix_core.sv
// Top level: wind-bent grass blade instance matrix pipeline.
//
//   channel   dir  handshake     payload
//   in_item   in   valid/ready   pos_x/y/z, blade_yaw, width_scale, height_scale, sway_phase
//   out_item  out  valid/ready   m00..m22, trans_x/y/z
//   cfg       in   cfg_we        cfg_index, cfg_data (write only)
//
// One instance per cycle sustained while the output is not stalled. From acceptance
// to out_item.valid an instance passes 6 phase stages, 10 per sine/cosine pipeline
// (two in series), 4 bend stages and 4 matrix stages. The whole pipeline advances together;
// when the output register is full and not taken, every stage holds and
// in_item.ready drops. Reset is synchronous; it clears the valid bits and loads the
// configuration registers with their defaults.
module wind_bent_instance_matrix_core import wbim_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  wbim_in_if.sink               in_item,
  wbim_out_if.source            out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic signed [15:0] wind_dir_x, wind_dir_z;
  logic        [15:0] phase_rate;
  logic        [14:0] bend_amp, gust_amp;
  logic        [29:0] frame_time;

  logic               advance;
  logic [LAT-1:0]     vld_q;
  side_t              side_q [LAT];

  logic        [31:0] ang1, ang2, tilt_x_ang, tilt_z_ang, yaw_ang;
  logic signed [15:0] s1, c1, s2, c2, txs, txc, tzs, tzc, yws, ywc;

  always_ff @(posedge clk) begin
    if (rst) begin
      wind_dir_x <= 16'sd16384;
      wind_dir_z <= '0;
      phase_rate <= 16'd256;
      bend_amp   <= '0;
      gust_amp   <= '0;
      frame_time <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIR_X:      wind_dir_x <= $signed(cfg_data[15:0]);
        REG_DIR_Z:      wind_dir_z <= $signed(cfg_data[15:0]);
        REG_SPEED:      phase_rate <= cfg_data[15:0];
        REG_STRENGTH:   bend_amp   <= cfg_data[14:0];
        REG_TURBULENCE: gust_amp   <= cfg_data[14:0];
        REG_FRAME_TIME: frame_time <= cfg_data[29:0];
        default: ;
      endcase
    end
  end

  assign advance       = !vld_q[LAT-1] || out_item.ready;
  assign in_item.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[LAT-2:0], in_item.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side_q[0].pos_x  <= in_item.pos_x;
      side_q[0].pos_y  <= in_item.pos_y;
      side_q[0].pos_z  <= in_item.pos_z;
      side_q[0].yaw    <= in_item.blade_yaw;
      side_q[0].width  <= in_item.width_scale;
      side_q[0].height <= in_item.height_scale;
      for (int i = 1; i < LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  wbim_phase u_phase (
    .clk        (clk),
    .en         (advance),
    .frame_time (frame_time),
    .phase_rate (phase_rate),
    .sway       (in_item.sway_phase),
    .ang1       (ang1),
    .ang2       (ang2)
  );

  wbim_cordic u_trig1 (.clk(clk), .en(advance), .ang(ang1), .sn(s1), .cs(c1));
  wbim_cordic u_trig2 (.clk(clk), .en(advance), .ang(ang2), .sn(s2), .cs(c2));

  wbim_bend u_bend (
    .clk        (clk),
    .en         (advance),
    .s1         (s1),
    .s2         (s2),
    .strength   (bend_amp),
    .turbulence (gust_amp),
    .dir_x      (wind_dir_x),
    .dir_z      (wind_dir_z),
    .yaw        (side_q[STG_YAW].yaw),
    .tilt_x_ang (tilt_x_ang),
    .tilt_z_ang (tilt_z_ang),
    .yaw_ang    (yaw_ang)
  );

  wbim_cordic u_trig_tx  (.clk(clk), .en(advance), .ang(tilt_x_ang), .sn(txs), .cs(txc));
  wbim_cordic u_trig_tz  (.clk(clk), .en(advance), .ang(tilt_z_ang), .sn(tzs), .cs(tzc));
  wbim_cordic u_trig_yaw (.clk(clk), .en(advance), .ang(yaw_ang), .sn(yws), .cs(ywc));

  wbim_matrix u_matrix (
    .clk (clk),
    .en  (advance),
    .txs (txs),
    .txc (txc),
    .tzs (tzs),
    .tzc (tzc),
    .yws (yws),
    .ywc (ywc),
    .wid (side_q[STG_SCALE].width),
    .hgt (side_q[STG_SCALE].height),
    .m00 (out_item.m00),
    .m01 (out_item.m01),
    .m02 (out_item.m02),
    .m10 (out_item.m10),
    .m11 (out_item.m11),
    .m12 (out_item.m12),
    .m20 (out_item.m20),
    .m21 (out_item.m21),
    .m22 (out_item.m22)
  );

  assign out_item.valid   = vld_q[LAT-1];
  assign out_item.trans_x = side_q[LAT-1].pos_x;
  assign out_item.trans_y = side_q[LAT-1].pos_y;
  assign out_item.trans_z = side_q[LAT-1].pos_z;

  // accepted transaction enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_item.valid && in_item.ready |=> vld_q[0])
    else $error("accepted transaction missing from stage 0");

  // a stall freezes the whole valid chain
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(vld_q))
    else $error("valid chain moved during stall");

  // sine outputs stay within +-1.0 in Q2.14
  a_sin_range: assert property (@(posedge clk) disable iff (rst)
    vld_q[15] |-> (s1 <= 16'sd16384 && s1 >= -16'sd16384 &&
                   s2 <= 16'sd16384 && s2 >= -16'sd16384))
    else $error("sine out of range");

endmodule
